@@ src/mf3_pkg.sv @@
// Shared constants for the 3x3 median filter: field widths, line buffer depth,
// configuration register indexes and their reset values. No dependencies.
package mf3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 32;
    localparam int ROW_W     = 16;
    localparam int FW_W      = 12;
    localparam int REGION_COL_W = 11;
    localparam int OUT_COL_W = 11;
    // comparison width wide enough for frame_width and for a column plus one
    localparam int CMP_W     = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd4;

    localparam logic [FW_W-1:0]         FRAME_WIDTH_RST   = 12'd640;
    localparam logic [REGION_COL_W-1:0] REGION_LEFT_RST   = 11'd1;
    localparam logic [ROW_W-1:0]        REGION_TOP_RST    = 16'd1;
    localparam logic [REGION_COL_W-1:0] REGION_RIGHT_RST  = 11'd639;
    localparam logic [ROW_W-1:0]        REGION_BOTTOM_RST = 16'd479;

    localparam logic [FW_W-1:0] MIN_FRAME_WIDTH = 12'd3;

endpackage

@@ src/mf3_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mf3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/median_filter_3x3_core.sv @@
// 3x3 median filter core over a raster pixel stream.
// Uses mf3_pkg for widths and register codes, and mf3_ram for the two line buffers.
//
// Pixels enter one word per clock on the s_ side in raster order; s_tuser[0]
// marks the first pixel of a frame. Two line buffers of MAX_WIDTH words each
// (one RAM per row, registered read) supply the two rows above, and a 3x3
// window of column-sorted words slides along. When the pixel below and to the
// right of a centre arrives and that centre lies inside the configured
// rectangle, the signed median of the nine words leaves on the m_ side with
// the centre's column and row. Sustained rate is one pixel per clock. Accepting
// a pixel starts its line buffer read and loads stage 1; stage 1 loads the
// window and the window loads the output register, which drives m_tvalid. The
// input stalls only while m_tready is low with a result waiting and the stages
// behind it full. The line buffers need no clearing pass after reset. Write
// configuration only while idle.
module median_filter_3x3_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mf3_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] pixel
    input  logic                            s_tuser,   // [0] frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mf3_pkg::OUT_DATA_W-1:0]  m_tdata,   // [31:0] median, [42:32] centre_col,
                                                       // [58:43] centre_row, [63:59] zero
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PIX_W = mf3_pkg::PIX_W;
    localparam int COL_W = mf3_pkg::COL_W;
    localparam int ROW_W = mf3_pkg::ROW_W;
    localparam int CMP_W = mf3_pkg::CMP_W;
    localparam int OCW   = mf3_pkg::OUT_COL_W;
    localparam int RCW   = mf3_pkg::REGION_COL_W;
    localparam int FW_W  = mf3_pkg::FW_W;

    // configuration
    logic [FW_W-1:0]  frame_width_reg;
    logic [RCW-1:0]   region_left_reg;
    logic [ROW_W-1:0] region_top_reg;
    logic [RCW-1:0]   region_right_reg;
    logic [ROW_W-1:0] region_bottom_reg;

    // position
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // stage 1: RAM read in flight
    logic                    s1_valid_reg;
    logic signed [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [OCW-1:0]          s1_ccol_reg;
    logic [ROW_W-1:0]        s1_crow_reg;
    logic                    s1_emit_reg;
    logic                    s1_byp_reg;
    logic signed [PIX_W-1:0] s1_byp_pix_reg;
    logic signed [PIX_W-1:0] s1_byp_mid_reg;

    // stage 2: window
    logic                    s2_valid_reg;
    logic                    s2_emit_reg;
    logic [OCW-1:0]          s2_ccol_reg;
    logic [ROW_W-1:0]        s2_crow_reg;
    logic signed [PIX_W-1:0] win_reg [9];

    // output
    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] out_median_reg;
    logic [OCW-1:0]          out_col_reg;
    logic [ROW_W-1:0]        out_row_reg;

    logic [CMP_W-1:0]        width_eff;
    logic [COL_W-1:0]        col_start;
    logic [ROW_W-1:0]        row_in;
    logic [COL_W-1:0]        col_in;
    logic [CMP_W-1:0]        col_inc;
    logic [COL_W-1:0]        col_next;
    logic [ROW_W-1:0]        row_next;
    logic [COL_W-1:0]        ccol_in;
    logic [ROW_W-1:0]        crow_in;
    logic                    emit_in;

    logic                    s_accept;
    logic                    out_free;
    logic                    s2_leave;
    logic                    s2_free;
    logic                    s1_go;
    logic                    collide;

    logic signed [PIX_W-1:0] ram_mid;
    logic signed [PIX_W-1:0] ram_top;
    logic signed [PIX_W-1:0] mid_eff;
    logic signed [PIX_W-1:0] top_eff;
    logic signed [PIX_W-1:0] col_lo;
    logic signed [PIX_W-1:0] col_md;
    logic signed [PIX_W-1:0] col_hi;
    logic signed [PIX_W-1:0] median_next;

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- control
    assign out_free = !out_valid_reg || m_tready;
    assign s2_leave = s2_valid_reg && (!s2_emit_reg || out_free);
    assign s2_free  = !s2_valid_reg || s2_leave;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------- position
    always_comb
    begin
        if (frame_width_reg < mf3_pkg::MIN_FRAME_WIDTH)
        begin
            width_eff = CMP_W'(mf3_pkg::MIN_FRAME_WIDTH);
        end
        else if (CMP_W'(frame_width_reg) > CMP_W'(mf3_pkg::MAX_WIDTH))
        begin
            width_eff = CMP_W'(mf3_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = CMP_W'(frame_width_reg);
        end

        col_start = s_tuser ? '0 : col_reg;
        row_in    = s_tuser ? '0 : row_reg;
        col_in    = (CMP_W'(col_start) >= width_eff) ? '0 : col_start;
        col_inc   = CMP_W'(col_in) + CMP_W'(1);
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = row_in + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_in;
        end

        ccol_in = col_in - COL_W'(1);
        crow_in = row_in - ROW_W'(1);
        emit_in = (CMP_W'(col_in) >= CMP_W'(2)) && (row_in >= ROW_W'(2))
                  && (CMP_W'(ccol_in) >= CMP_W'(region_left_reg))
                  && (CMP_W'(ccol_in) <  CMP_W'(region_right_reg))
                  && (crow_in >= region_top_reg)
                  && (crow_in <  region_bottom_reg);
    end

    // the word in stage 1 writes its column as the new word reads it: forward
    assign collide = s1_go && (s1_col_reg == col_in);

    // ---------------------------------------------------------------- line buffers
    mf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_row_mid (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (s_accept),
        .rd_addr (col_in),
        .rd_data (ram_mid)
    );

    mf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_row_top (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (mid_eff),
        .rd_en   (s_accept),
        .rd_addr (col_in),
        .rd_data (ram_top)
    );

    assign mid_eff = s1_byp_reg ? s1_byp_pix_reg : ram_mid;
    assign top_eff = s1_byp_reg ? s1_byp_mid_reg : ram_top;

    // sort the incoming column before it enters the window
    always_comb
    begin
        logic signed [PIX_W-1:0] a;
        logic signed [PIX_W-1:0] b;
        logic signed [PIX_W-1:0] c;
        logic signed [PIX_W-1:0] t;
        t = '0;
        a = top_eff;
        b = mid_eff;
        c = s1_pix_reg;
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (b > c)
        begin
            t = b; b = c; c = t;
        end
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        col_lo = a;
        col_md = b;
        col_hi = c;
    end

    // median of three sorted columns
    always_comb
    begin
        logic signed [PIX_W-1:0] q [9];
        logic signed [PIX_W-1:0] t;
        t = '0;
        q = win_reg;
        if (q[0] > q[3]) begin t = q[0]; q[0] = q[3]; q[3] = t; end
        if (q[5] > q[8]) begin t = q[5]; q[5] = q[8]; q[8] = t; end
        if (q[4] > q[7]) begin t = q[4]; q[4] = q[7]; q[7] = t; end
        if (q[3] > q[6]) begin t = q[3]; q[3] = q[6]; q[6] = t; end
        if (q[1] > q[4]) begin t = q[1]; q[1] = q[4]; q[4] = t; end
        if (q[2] > q[5]) begin t = q[2]; q[2] = q[5]; q[5] = t; end
        if (q[4] > q[7]) begin t = q[4]; q[4] = q[7]; q[7] = t; end
        if (q[4] > q[2]) begin t = q[4]; q[4] = q[2]; q[2] = t; end
        if (q[6] > q[4]) begin t = q[6]; q[6] = q[4]; q[4] = t; end
        if (q[4] > q[2]) begin t = q[4]; q[4] = q[2]; q[2] = t; end
        median_next = q[4];
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= mf3_pkg::FRAME_WIDTH_RST;
            region_left_reg   <= mf3_pkg::REGION_LEFT_RST;
            region_top_reg    <= mf3_pkg::REGION_TOP_RST;
            region_right_reg  <= mf3_pkg::REGION_RIGHT_RST;
            region_bottom_reg <= mf3_pkg::REGION_BOTTOM_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mf3_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_W-1:0];
                mf3_pkg::REG_REGION_LEFT:   region_left_reg   <= cfg_data[RCW-1:0];
                mf3_pkg::REG_REGION_TOP:    region_top_reg    <= cfg_data[ROW_W-1:0];
                mf3_pkg::REG_REGION_RIGHT:  region_right_reg  <= cfg_data[RCW-1:0];
                mf3_pkg::REG_REGION_BOTTOM: region_bottom_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_byp_reg    <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_emit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (s_accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                s1_byp_reg   <= collide;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
                s1_byp_reg   <= 1'b0;
            end

            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
                s2_emit_reg  <= s1_emit_reg;
                for (int k = 0; k < 6; k++)
                begin
                    win_reg[k] <= win_reg[k + 3];
                end
                win_reg[6] <= col_lo;
                win_reg[7] <= col_md;
                win_reg[8] <= col_hi;
            end
            else if (s2_leave)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_leave && s2_emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_pix_reg     <= s_tdata[PIX_W-1:0];
            s1_col_reg     <= col_in;
            s1_ccol_reg    <= OCW'(ccol_in);
            s1_crow_reg    <= crow_in;
            s1_emit_reg    <= emit_in;
            s1_byp_pix_reg <= s1_pix_reg;
            s1_byp_mid_reg <= mid_eff;
        end
        if (s1_go)
        begin
            s2_ccol_reg <= s1_ccol_reg;
            s2_crow_reg <= s1_crow_reg;
        end
        if (s2_leave && s2_emit_reg)
        begin
            out_median_reg <= median_next;
            out_col_reg    <= s2_ccol_reg;
            out_row_reg    <= s2_crow_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mf3_pkg::OUT_DATA_W - PIX_W - OCW - ROW_W){1'b0}},
                       out_row_reg, out_col_reg, out_median_reg};

`ifndef NO_ASSERTIONS
    // forwarding only applies to a word held in stage 1
    assert property (@(posedge clk) disable iff (!rst_n) s1_byp_reg |-> s1_valid_reg)
        else $error("forward flag set with stage 1 empty");

    // a word that yields no result never holds up the window
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_emit_reg) |-> s2_leave)
        else $error("non-emitting word stalled in window stage");

    // window holds while its word waits for the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_leave) |=> ($stable(win_reg[4]) && $stable(win_reg[8])))
        else $error("window shifted under a waiting word");

    // centres in row zero of the frame are never emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_row_reg != '0))
        else $error("result for a centre in row zero");
`endif

endmodule

@@ dv/median_filter_3x3_checker.sv @@
`timescale 1ns / 100ps
// Checker for median_filter_3x3_core: mirrors the line buffers and the 3x3 window,
// predicts each median word and compares it with the m_ side. Depends on mf3_pkg.
module median_filter_3x3_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mf3_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] pixel
    input  logic                            s_tuser,   // [0] frame_start
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mf3_pkg::OUT_DATA_W-1:0]  m_tdata,   // [31:0] median, [42:32] centre_col,
                                                       // [58:43] centre_row, [63:59] zero
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import mf3_pkg::*;

    localparam int WIN_TAPS    = 9;
    localparam int MEDIAN_RANK = 4;
    localparam int COL_LSB     = PIX_W;
    localparam int ROW_LSB     = COL_LSB + OUT_COL_W;
    localparam int PAD_LSB     = ROW_LSB + ROW_W;

    typedef struct packed {
        logic [PIX_W-1:0]     median;
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
    } median_word_t;

    median_word_t                 median_q[$];
    logic [PIX_W-1:0]             line_mem [0:2*MAX_WIDTH-1];
    logic [WIN_TAPS-1:0][PIX_W-1:0] win;
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    int                           fail_tally;

    logic [FW_W-1:0]         frame_width;
    logic [REGION_COL_W-1:0] left_col;
    logic [REGION_COL_W-1:0] right_col;
    logic [ROW_W-1:0]        top_row;
    logic [ROW_W-1:0]        bottom_row;

    assign mismatches = fail_tally;

    function automatic logic [PIX_W-1:0] window_median(
        input logic [WIN_TAPS-1:0][PIX_W-1:0] taps
    );
        logic signed [PIX_W-1:0] s [0:WIN_TAPS-1];
        logic signed [PIX_W-1:0] v;
        int i;
        int j;
        for (i = 0; i < WIN_TAPS; i++)
            s[i] = taps[i];
        // insertion sort in signed order
        for (i = 1; i < WIN_TAPS; i++)
        begin
            v = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > v)
            begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = v;
        end
        return s[MEDIAN_RANK];
    endfunction

    task automatic place_pixel(input logic [PIX_W-1:0] pix, input logic start);
        int unsigned  span;
        int unsigned  c;
        int unsigned  r;
        int unsigned  ccol;
        int unsigned  crow;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        median_word_t res;
        span = frame_width;
        if (span < MIN_FRAME_WIDTH)
            span = MIN_FRAME_WIDTH;
        if (span > MAX_WIDTH)
            span = MAX_WIDTH;
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= span)
            col_pos = 0;
        c = col_pos;
        r = row_pos;

        upper  = line_mem[MAX_WIDTH + c];
        middle = line_mem[c];
        line_mem[MAX_WIDTH + c] = middle;
        line_mem[c] = pix;
        // newest column enters at the top taps
        win = {pix, middle, upper, win[WIN_TAPS-1:3]};

        if (c + 1 >= span)
        begin
            col_pos = 0;
            row_pos = (r + 1) & 16'hFFFF;
        end
        else
            col_pos = c + 1;

        if (c >= 2 && r >= 2)
        begin
            ccol = c - 1;
            crow = r - 1;
            if (ccol >= left_col && ccol < right_col && crow >= top_row && crow < bottom_row)
            begin
                res.median = window_median(win);
                res.col    = ccol[OUT_COL_W-1:0];
                res.row    = crow[ROW_W-1:0];
                median_q.push_back(res);
            end
        end
    endtask

    task automatic compare_word(input logic [OUT_DATA_W-1:0] word);
        median_word_t want;
        if (median_q.size() == 0)
        begin
            $display("%0t: median word %h arrived with nothing expected", $time, word);
            fail_tally++;
        end
        else
        begin
            want = median_q.pop_front();
            if (word[PIX_W-1:0] !== want.median)
            begin
                $display("%0t: median expected %h actual %h", $time, want.median,
                         word[PIX_W-1:0]);
                fail_tally++;
            end
            if (word[COL_LSB +: OUT_COL_W] !== want.col)
            begin
                $display("%0t: centre_col expected %0d actual %0d", $time, want.col,
                         word[COL_LSB +: OUT_COL_W]);
                fail_tally++;
            end
            if (word[ROW_LSB +: ROW_W] !== want.row)
            begin
                $display("%0t: centre_row expected %0d actual %0d", $time, want.row,
                         word[ROW_LSB +: ROW_W]);
                fail_tally++;
            end
            if (word[OUT_DATA_W-1:PAD_LSB] !== '0)
            begin
                $display("%0t: pad bits expected 0 actual %h", $time,
                         word[OUT_DATA_W-1:PAD_LSB]);
                fail_tally++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_q.delete();
            win         = '0;
            col_pos     = 0;
            row_pos     = 0;
            fail_tally  = 0;
            frame_width = FRAME_WIDTH_RST;
            left_col    = REGION_LEFT_RST;
            top_row     = REGION_TOP_RST;
            right_col   = REGION_RIGHT_RST;
            bottom_row  = REGION_BOTTOM_RST;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:   frame_width = cfg_data[FW_W-1:0];
                    REG_REGION_LEFT:   left_col    = cfg_data[REGION_COL_W-1:0];
                    REG_REGION_TOP:    top_row     = cfg_data[ROW_W-1:0];
                    REG_REGION_RIGHT:  right_col   = cfg_data[REGION_COL_W-1:0];
                    REG_REGION_BOTTOM: bottom_row  = cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                place_pixel(s_tdata[PIX_W-1:0], s_tuser);
            if (m_tvalid && m_tready)
                compare_word(m_tdata);
            outstanding <= median_q.size();
        end
    end

endmodule

@@ dv/tb_median_filter_3x3_core.sv @@
`timescale 1ns / 100ps
// Top of the median filter testbench: drives pixel frames and register writes into
// median_filter_3x3_core and gives the verdict. Depends on mf3_pkg and the checker.
module tb_median_filter_3x3_core;
    import mf3_pkg::*;

    // no register sits behind this index
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_WORDS  = 550;
    localparam int RESET_WORDS   = 64;

    typedef enum int { PIX_RANDOM, PIX_EXTREME, PIX_TIES, PIX_MIXED } pix_style_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;   // [31:0] pixel
    logic                   s_tuser;   // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;   // [31:0] median, [42:32] centre_col,
                                       // [58:43] centre_row, [63:59] zero
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int words_sent;
    bit gaps_on;
    bit stalls_on;
    bit hold_req;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    median_filter_3x3_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    median_filter_3x3_checker median_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side: stall per word, once hold off for a long stretch on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = stalls_on ? int'($urandom_range(0, 7)) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic configure(input int span, input int left, input int top,
                             input int right, input int bottom);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        write_reg(REG_FRAME_WIDTH, {junk[CFG_DATA_W-1:FW_W], FW_W'(span)});
        write_reg(REG_REGION_LEFT, {junk[CFG_DATA_W-1:REGION_COL_W], REGION_COL_W'(left)});
        write_reg(REG_REGION_TOP, CFG_DATA_W'(top));
        write_reg(REG_REGION_RIGHT, {junk[CFG_DATA_W-1:REGION_COL_W], REGION_COL_W'(right)});
        write_reg(REG_REGION_BOTTOM, CFG_DATA_W'(bottom));
    endtask

    task automatic send_word(input logic [PIX_W-1:0] pix, input logic start);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style);
        pix_style_t kind;
        kind = style;
        if (style == PIX_MIXED)
            kind = pix_style_t'($urandom_range(0, 2));
        case (kind)
            PIX_EXTREME:
                case ($urandom_range(0, 7))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h8000_0001;
                    5: return 32'h7FFF_FFFE;
                    6: return 32'h0000_0001;
                    default: return 32'hC000_0000;
                endcase
            PIX_TIES: return $urandom_range(0, 4) - 2;
            default:  return $urandom();
        endcase
    endfunction

    // fresh: open a new frame; noisy: scatter stray frame starts
    task automatic send_frame(input int span, input int rows, input int tail,
                              input pix_style_t style, input bit fresh, input bit noisy);
        int n;
        int total;
        logic start;
        total = span * rows + tail;
        for (n = 0; n < total; n++)
        begin
            start = (n == 0 && fresh) || (noisy && $urandom_range(0, 63) == 0);
            send_word(pick_pixel(style), start);
        end
    endtask

    // hold input until every predicted word has arrived, then let the pipeline empty
    task automatic drain();
        int waited;
        s_tvalid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int base;
        int phase;
        int span;
        int eff;
        int frames;
        int f;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_FRAME_WIDTH;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        stalls_on  = 1'b1;
        hold_req   = 1'b0;
        words_sent = 0;
        rst_n      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: the start of a 640-wide frame yields nothing
        send_frame(640, 0, RESET_WORDS, PIX_MIXED, 1'b1, 1'b0);
        drain();

        // extreme words through a 3-wide frame; the spare index must change nothing
        configure(3, 1, 1, 2, 16'hFFFF);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
        send_frame(3, 8, 0, PIX_EXTREME, 1'b1, 1'b0);
        drain();

        // width below minimum acts as 3; region opened to column and row 0
        configure(0, 0, 0, 2047, 16'hFFFF);
        send_frame(3, 5, 0, PIX_MIXED, 1'b1, 1'b0);
        drain();

        // empty column range, then empty row range at the top of the row space
        configure(6, 4, 1, 4, 100);
        send_frame(6, 4, 0, PIX_MIXED, 1'b1, 1'b0);
        drain();
        configure(6, 1, 16'hFFFF, 5, 16'hFFFF);
        send_frame(6, 4, 0, PIX_MIXED, 1'b1, 1'b0);
        drain();

        base  = words_sent;
        phase = 0;
        while (words_sent < base + RANDOM_WORDS)
        begin
            span = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2))
                                               : int'($urandom_range(3, 10));
            eff  = (span < 3) ? 3 : span;
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            if (phase == 0)
            begin
                // fill the block against a stopped receiver
                configure(8, 1, 1, 7, 100);
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                send_frame(8, 12, 0, PIX_MIXED, 1'b1, 1'b0);
                send_frame(8, 12, 0, PIX_MIXED, 1'b1, 1'b0);
            end
            else
            begin
                configure(span, $urandom_range(0, 4), $urandom_range(0, 3),
                          $urandom_range(0, eff + 1), $urandom_range(0, 8));
                frames = $urandom_range(1, 3);
                for (f = 0; f < frames; f++)
                begin
                    if (phase == 1 && f == 0)
                    begin
                        // pause inside a frame until all results are out
                        send_frame(eff, 3, 1, PIX_MIXED, 1'b1, 1'b0);
                        drain();
                        send_frame(eff, 2, 0, PIX_MIXED, 1'b0, 1'b0);
                    end
                    else
                        send_frame(eff, $urandom_range(2, 7), $urandom_range(0, eff - 1),
                                   PIX_MIXED, 1'b1, 1'b1);
                end
            end
            drain();
            phase++;
        end

        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
        begin
            if (outstanding != 0)
                $display("%0t: %0d median words never arrived", $time, outstanding);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
